// ===== hdl/rbid_pkg.sv =====
// ----------------------------------------------------------------------------
// rbid_pkg
// Shared types and constants for the relay bank with impulse and dependency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbid_pkg;

  // default relay count and fixed field widths
  localparam int NUM_RELAYS_DEF = 8;
  localparam int MASK_W         = 8;
  localparam int TIME_W         = 32;

  // register reset values
  localparam logic [MASK_W-1:0] IMPULSE_MASK_RST     = '0;
  localparam logic [MASK_W-1:0] INDEPENDENT_MASK_RST = '0;
  localparam logic [31:0]       DEPENDS_MAP_RST      = 32'hFFFF_FFFF;
  localparam logic [TIME_W-1:0] INTERVAL_RST         = 32'd250;

  // operation codes
  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_TOGGLE  = 2'd1,
    OP_CHECK   = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  // register indexes
  typedef enum logic [1:0] {
    REG_IMPULSE_MASK     = 2'd0,
    REG_INDEPENDENT_MASK = 2'd1,
    REG_DEPENDS_MAP      = 2'd2,
    REG_INTERVAL         = 2'd3
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHAIN,
    ST_APPLY,
    ST_CHECK,
    ST_REL_OUTER,
    ST_REL_INNER,
    ST_SUMMARY
  } state_e;

  // input item
  typedef struct packed {
    logic [1:0]        operation;
    logic [2:0]        relay_index;
    logic              req_state;
    logic [TIME_W-1:0] now_ms;
  } cmd_item_t;

  // result item
  typedef struct packed {
    logic              is_notice;
    logic [2:0]        changed_relay;
    logic              changed_state;
    logic              return_flag;
    logic [MASK_W-1:0] relay_states;
    logic              last;
  } res_item_t;

  // configuration write
  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // dependency lookup result
  typedef struct packed {
    logic       valid;
    logic [2:0] relay;
  } dep_t;

endpackage

`default_nettype wire

// ===== hdl/rbid_if.sv =====
// ----------------------------------------------------------------------------
// rbid_if
// Valid/ready channels for commands, results and configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// command channel
interface rbid_cmd_if;
  logic                 valid;
  logic                 ready;
  rbid_pkg::cmd_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// result channel
interface rbid_res_if;
  logic                 valid;
  logic                 ready;
  rbid_pkg::res_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// configuration write channel
interface rbid_cfg_if;
  logic                 valid;
  logic                 ready;
  rbid_pkg::cfg_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== hdl/rbid_dep_lookup.sv =====
// ----------------------------------------------------------------------------
// rbid_dep_lookup
// Decodes the dependency code of one selected relay from the map register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbid_dep_lookup #(
  parameter  int NUM_RELAYS = rbid_pkg::NUM_RELAYS_DEF,
  localparam int ACTIVE     = (NUM_RELAYS < 8) ? NUM_RELAYS : 8,
  localparam int IDX_W      = $clog2(ACTIVE)
) (
  input  wire logic [31:0]      depends_map,
  input  wire logic [IDX_W-1:0] sel,
  output rbid_pkg::dep_t        dep
);

  logic [3:0] code;

  // codes past the active count or pointing at itself mean no dependency
  always_comb begin
    code      = depends_map[{sel, 2'b00} +: 4];
    dep.valid = (code < 4'(ACTIVE)) && (code != 4'(sel));
    dep.relay = code[2:0];
  end

endmodule

`default_nettype wire

// ===== hdl/relay_bank_impulse_dependency.sv =====
// ----------------------------------------------------------------------------
// relay_bank_impulse_dependency
// Relay bank with impulse timeouts and dependency chains.
// cmd takes one item (set, toggle, impulse check, release); res returns a
// notice per relay change, then one summary item with last set. cfg writes
// the four registers; the user is to write them only while the block is
// idle, which the block itself does not enforce. cfg is always ready.
// One item is handled by a small sequencer around a single dependency lookup
// and a single 32-bit add/compare. Set/toggle on follows the dependency
// chain (<= 8 relays); check and release scan the relays. cmd is ready only
// while the sequencer is idle. Results go through one output register; a
// stalled receiver holds the sequencer at its next result, and the next item
// is taken while the summary still waits. Reset clears all relays and
// impulse timers and sets the registers to their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module relay_bank_impulse_dependency #(
  parameter int NUM_RELAYS = rbid_pkg::NUM_RELAYS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rbid_cfg_if.sink   cfg,
  rbid_cmd_if.sink   cmd,
  rbid_res_if.source res
);

  localparam int ACTIVE = (NUM_RELAYS < 8) ? NUM_RELAYS : 8;
  localparam int IDX_W  = $clog2(ACTIVE);
  localparam int CNT_W  = $clog2(ACTIVE + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(ACTIVE - 1);

  // configuration registers
  logic [rbid_pkg::MASK_W-1:0] impulse_mask;
  logic [rbid_pkg::MASK_W-1:0] independent_mask;
  logic [31:0]                 depends_map;
  logic [rbid_pkg::TIME_W-1:0] interval;

  // relay state
  logic [ACTIVE-1:0]           relay_on;
  logic [rbid_pkg::TIME_W-1:0] impulse_start [ACTIVE];
  logic [3:0]                  pending;
  logic                        any_dep;

  // sequencer
  rbid_pkg::state_e            state, state_next;
  logic [1:0]                  op;
  logic [rbid_pkg::TIME_W-1:0] now_reg;
  logic                        tgt;
  logic                        changed;
  logic [IDX_W-1:0]            chain [ACTIVE];
  logic [CNT_W-1:0]            len;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            sub;
  logic                        found_dep;
  logic                        found_on;

  // output register
  logic                        out_valid;
  rbid_pkg::res_item_t         out_item;

  // combinational control
  logic                        out_free;
  logic                        accept;
  logic                        r_ok;
  logic [IDX_W-1:0]            r_in;
  logic                        s_eff;
  logic [CNT_W-1:0]            len_dec;
  logic [IDX_W-1:0]            cur_x;
  logic [IDX_W-1:0]            sel;
  rbid_pkg::dep_t              dep;
  logic [ACTIVE-1:0]           imp_act;
  logic [ACTIVE-1:0]           ind_act;
  logic [rbid_pkg::TIME_W-1:0] st_ms;
  logic [rbid_pkg::TIME_W-1:0] end_ms;
  logic                        expired;
  logic                        hit;
  logic                        fd;
  logic                        fo;
  logic                        apply_en;
  logic [IDX_W-1:0]            apply_idx;
  logic                        apply_val;
  logic [ACTIVE-1:0]           on_next;
  logic                        emit_summary;
  logic                        sum_flag;

  assign out_free  = !out_valid || res.ready;
  assign cmd.ready = (state == rbid_pkg::ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid;
  assign res.item  = out_item;

  assign imp_act = impulse_mask[ACTIVE-1:0];
  assign ind_act = independent_mask[ACTIVE-1:0];

  // command decode
  assign r_ok  = ({1'b0, cmd.item.relay_index} < 4'(ACTIVE));
  assign r_in  = cmd.item.relay_index[IDX_W-1:0];
  assign s_eff = (cmd.item.operation == rbid_pkg::OP_TOGGLE) ? !relay_on[r_in]
                                                             : cmd.item.req_state;

  // chain head and shared dependency lookup
  assign len_dec = len - CNT_W'(1);
  assign cur_x   = chain[len_dec[IDX_W-1:0]];
  assign sel     = (state == rbid_pkg::ST_REL_INNER) ? sub : cur_x;

  rbid_dep_lookup #(
    .NUM_RELAYS (NUM_RELAYS)
  ) u_dep (
    .depends_map (depends_map),
    .sel         (sel),
    .dep         (dep)
  );

  // shared impulse timer compare
  assign st_ms   = impulse_start[idx];
  assign end_ms  = st_ms + interval;
  assign expired = imp_act[idx] && (st_ms != '0) && relay_on[idx] &&
                   ((now_reg > end_ms) || (now_reg < st_ms));

  // master scan of the release pass
  assign hit = dep.valid && (dep.relay == 3'(idx));
  assign fd  = found_dep || hit;
  assign fo  = found_on || (hit && relay_on[sub]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rbid_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.item.operation)
            rbid_pkg::OP_SET, rbid_pkg::OP_TOGGLE: begin
              if (!r_ok) state_next = rbid_pkg::ST_SUMMARY;
              else if (s_eff) state_next = rbid_pkg::ST_CHAIN;
              else state_next = rbid_pkg::ST_APPLY;
            end
            rbid_pkg::OP_CHECK: begin
              state_next = (pending != '0) ? rbid_pkg::ST_CHECK : rbid_pkg::ST_SUMMARY;
            end
            default: begin
              state_next = any_dep ? rbid_pkg::ST_REL_OUTER : rbid_pkg::ST_SUMMARY;
            end
          endcase
        end
      end
      rbid_pkg::ST_CHAIN: begin
        if (!((len < CNT_W'(ACTIVE)) && dep.valid)) state_next = rbid_pkg::ST_APPLY;
      end
      rbid_pkg::ST_APPLY: begin
        if (out_free && (len == CNT_W'(1))) state_next = rbid_pkg::ST_SUMMARY;
      end
      rbid_pkg::ST_CHECK: begin
        if (out_free && (idx == LAST)) state_next = rbid_pkg::ST_SUMMARY;
      end
      rbid_pkg::ST_REL_OUTER: begin
        if (!ind_act[idx] && relay_on[idx]) state_next = rbid_pkg::ST_REL_INNER;
        else if (idx == LAST) state_next = rbid_pkg::ST_SUMMARY;
      end
      rbid_pkg::ST_REL_INNER: begin
        if (out_free && (sub == LAST)) begin
          state_next = (idx == LAST) ? rbid_pkg::ST_SUMMARY : rbid_pkg::ST_REL_OUTER;
        end
      end
      rbid_pkg::ST_SUMMARY: begin
        if (out_free) state_next = rbid_pkg::ST_IDLE;
      end
      default: state_next = rbid_pkg::ST_IDLE;
    endcase
  end

  // relay change control
  always_comb begin
    apply_en     = 1'b0;
    apply_idx    = idx;
    apply_val    = 1'b0;
    emit_summary = 1'b0;
    case (state)
      rbid_pkg::ST_APPLY: begin
        apply_idx = cur_x;
        apply_val = tgt;
        apply_en  = out_free && (relay_on[cur_x] != tgt);
      end
      rbid_pkg::ST_CHECK: begin
        apply_en = out_free && expired;
      end
      rbid_pkg::ST_REL_INNER: begin
        apply_en = out_free && (sub == LAST) && fd && !fo;
      end
      rbid_pkg::ST_SUMMARY: begin
        emit_summary = out_free;
      end
      default: begin
        apply_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    on_next = relay_on;
    if (apply_en) on_next[apply_idx] = apply_val;
  end

  // summary flag per operation
  always_comb begin
    case (op)
      rbid_pkg::OP_SET, rbid_pkg::OP_TOGGLE: sum_flag = changed;
      rbid_pkg::OP_RELEASE:                  sum_flag = any_dep;
      default:                               sum_flag = 1'b0;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      impulse_mask     <= rbid_pkg::IMPULSE_MASK_RST;
      independent_mask <= rbid_pkg::INDEPENDENT_MASK_RST;
      depends_map      <= rbid_pkg::DEPENDS_MAP_RST;
      interval         <= rbid_pkg::INTERVAL_RST;
      state            <= rbid_pkg::ST_IDLE;
      relay_on         <= '0;
      for (int i = 0; i < ACTIVE; i++) impulse_start[i] <= '0;
      pending          <= '0;
      any_dep          <= 1'b0;
      out_valid        <= 1'b0;
      op               <= rbid_pkg::OP_SET;
      tgt              <= 1'b0;
      changed          <= 1'b0;
      len              <= '0;
      idx              <= '0;
      sub              <= '0;
      found_dep        <= 1'b0;
      found_on         <= 1'b0;
    end else begin
      state    <= state_next;
      relay_on <= on_next;

      // register writes
      if (cfg.valid) begin
        case (cfg.item.index)
          rbid_pkg::REG_IMPULSE_MASK:     impulse_mask     <= cfg.item.data[7:0];
          rbid_pkg::REG_INDEPENDENT_MASK: independent_mask <= cfg.item.data[7:0];
          rbid_pkg::REG_DEPENDS_MAP:      depends_map      <= cfg.item.data;
          rbid_pkg::REG_INTERVAL:         interval         <= cfg.item.data;
          default:                        interval         <= interval;
        endcase
      end

      // impulse timer bookkeeping
      if (apply_en && imp_act[apply_idx]) begin
        impulse_start[apply_idx] <= apply_val ? now_reg : '0;
        pending <= apply_val ? pending + 4'd1 : pending - 4'd1;
      end

      // output valid
      if (apply_en || emit_summary) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;

      case (state)
        rbid_pkg::ST_IDLE: begin
          if (accept) begin
            op      <= cmd.item.operation;
            tgt     <= s_eff;
            changed <= 1'b0;
            len     <= CNT_W'(1);
            idx     <= '0;
            if ((cmd.item.operation == rbid_pkg::OP_RELEASE) && any_dep) any_dep <= 1'b0;
          end
        end
        rbid_pkg::ST_CHAIN: begin
          if ((len < CNT_W'(ACTIVE)) && dep.valid) len <= len + CNT_W'(1);
        end
        rbid_pkg::ST_APPLY: begin
          if (out_free) begin
            if (tgt && dep.valid) any_dep <= 1'b1;
            if (len == CNT_W'(1)) changed <= (relay_on[cur_x] != tgt);
            len <= len_dec;
          end
        end
        rbid_pkg::ST_CHECK: begin
          if (out_free) idx <= idx + IDX_W'(1);
        end
        rbid_pkg::ST_REL_OUTER: begin
          if (!ind_act[idx] && relay_on[idx]) begin
            sub       <= '0;
            found_dep <= 1'b0;
            found_on  <= 1'b0;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        rbid_pkg::ST_REL_INNER: begin
          if (out_free) begin
            if (sub == LAST) begin
              if (fd && fo) any_dep <= 1'b1;
              idx <= idx + IDX_W'(1);
            end else begin
              sub       <= sub + IDX_W'(1);
              found_dep <= fd;
              found_on  <= fo;
            end
          end
        end
        default: begin
          sub <= sub;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_reg  <= cmd.item.now_ms;
      chain[0] <= r_in;
    end
    if ((state == rbid_pkg::ST_CHAIN) && (len < CNT_W'(ACTIVE)) && dep.valid) begin
      chain[len[IDX_W-1:0]] <= dep.relay[IDX_W-1:0];
    end
    if (apply_en) begin
      out_item.is_notice     <= 1'b1;
      out_item.changed_relay <= 3'(apply_idx);
      out_item.changed_state <= apply_val;
      out_item.return_flag   <= 1'b0;
      out_item.relay_states  <= 8'(on_next);
      out_item.last          <= 1'b0;
    end else if (emit_summary) begin
      out_item.is_notice     <= 1'b0;
      out_item.changed_relay <= 3'd0;
      out_item.changed_state <= 1'b0;
      out_item.return_flag   <= sum_flag;
      out_item.relay_states  <= 8'(relay_on);
      out_item.last          <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // every accepted item starts work, at least a summary
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != rbid_pkg::ST_IDLE))
    else $error("sequencer stayed idle after an accepted item");

  // a notice shows the changed relay in its new state
  a_notice_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.is_notice) |->
      (out_item.relay_states[out_item.changed_relay] == out_item.changed_state))
    else $error("notice disagrees with its relay bitmap");

  // the dependency chain never outgrows the relay count
  a_chain_len: assert property (@(posedge clk) disable iff (rst)
    (state == rbid_pkg::ST_CHAIN) |-> (len <= CNT_W'(ACTIVE)) && (len != '0))
    else $error("dependency chain length out of range");
`endif

endmodule

`default_nettype wire
